// ----- rtl/core/mvm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants of the matrix-vector multiply block.
// ----------------------------------------------------------------------------
package mvm_pkg;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_MAC  = 1'b1;

   typedef logic [12:0]        size_type;
   typedef logic [11:0]        row_index_type;
   typedef logic signed [31:0] value_type;
   typedef logic signed [63:0] sum_type;

   localparam size_type SIZE_RESET = 13'd4;

   typedef struct packed {
      logic      command;
      value_type value;
   } req_word_type;

   typedef struct packed {
      row_index_type row_index;
      sum_type       row_sum;
      logic          saturated;
      logic          last_row;
   } rsp_word_type;

   typedef struct packed {
      logic          is_mac;
      logic          end_row;
      logic          last;
      row_index_type row_index;
   } ctrl_type;

endpackage

// ----- rtl/core/mvm_vector_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_vector_store
// Vector element memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mvm_vector_store #(
   parameter int MAX_SIZE = 4096
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(MAX_SIZE)-1:0] wr_addr,
   input  mvm_pkg::value_type          wr_data,
   input  logic                        rd_en,
   input  logic [$clog2(MAX_SIZE)-1:0] rd_addr,
   output mvm_pkg::value_type          rd_data_ff
);

   mvm_pkg::value_type mem [MAX_SIZE];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/core/mvm_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_sequencer
// Load, column and row counters; issues memory accesses and stage-one control.
// ----------------------------------------------------------------------------
module mvm_sequencer #(
   parameter int MAX_SIZE = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        accept,
   input  mvm_pkg::req_word_type       req_word,
   input  mvm_pkg::size_type           size,
   output logic                        wr_en,
   output logic [$clog2(MAX_SIZE)-1:0] wr_addr,
   output mvm_pkg::value_type          wr_data,
   output logic [$clog2(MAX_SIZE)-1:0] rd_addr,
   output logic                        s1_valid_ff,
   output mvm_pkg::ctrl_type           s1_ctrl_ff,
   output mvm_pkg::value_type          s1_value_ff
);

   localparam int AW = $clog2(MAX_SIZE);
   localparam int CW = $clog2(MAX_SIZE + 1);

   logic [CW-1:0] n_eff;
   logic [CW-1:0] load_pos_ff, load_pos_in;
   logic [AW-1:0] col_ff, col_in;
   logic [AW-1:0] row_ff, row_in;
   logic [CW-1:0] col_plus;
   logic [CW-1:0] row_plus;
   logic          end_row;
   logic          last;
   logic          is_mac;
   logic          do_load;

   always_comb begin
      priority if (size == '0) begin
         n_eff = CW'(1);
      end else if (int'(size) > MAX_SIZE) begin
         n_eff = CW'(MAX_SIZE);
      end else begin
         n_eff = CW'(size);
      end
   end

   assign col_plus = CW'(col_ff) + CW'(1);
   assign row_plus = CW'(row_ff) + CW'(1);
   assign end_row  = col_plus >= n_eff;
   assign last     = row_plus >= n_eff;
   assign is_mac   = req_word.command == mvm_pkg::CMD_MAC;
   assign do_load  = accept && !is_mac && (load_pos_ff < n_eff);

   assign wr_en   = do_load;
   assign wr_addr = load_pos_ff[AW-1:0];
   assign wr_data = req_word.value;
   assign rd_addr = col_ff;

   always_comb begin
      load_pos_in = load_pos_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (accept) begin
         if (!is_mac) begin
            if (do_load) begin
               load_pos_in = load_pos_ff + CW'(1);
            end
            col_in = '0;
            row_in = '0;
         end else if (end_row) begin
            col_in = '0;
            row_in = last ? '0 : row_plus[AW-1:0];
         end else begin
            col_in = col_plus[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         load_pos_ff <= load_pos_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         if (adv) begin
            s1_valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctrl_ff.is_mac    <= is_mac;
         s1_ctrl_ff.end_row   <= end_row;
         s1_ctrl_ff.last      <= last;
         s1_ctrl_ff.row_index <= mvm_pkg::row_index_type'(row_ff);
         s1_value_ff          <= req_word.value;
      end
   end

   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && !is_mac |=> col_ff == '0 && row_ff == '0)
      else $error("vector load did not restart counters");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      accept && is_mac && end_row && last |=> row_ff == '0)
      else $error("row counter did not wrap after last row");

   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      load_pos_ff <= CW'(MAX_SIZE))
      else $error("load position beyond store depth");

endmodule

// ----- rtl/core/mvm_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_accumulator
// Product register, saturating row accumulator and result register.
// ----------------------------------------------------------------------------
module mvm_accumulator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  s1_valid,
   input  mvm_pkg::ctrl_type     s1_ctrl,
   input  mvm_pkg::value_type    s1_value,
   input  mvm_pkg::value_type    vec_data,
   output logic                  out_valid_ff,
   output mvm_pkg::rsp_word_type out_word_ff
);

   logic              s2_valid_ff;
   mvm_pkg::ctrl_type s2_ctrl_ff;
   mvm_pkg::sum_type  prod_ff;
   mvm_pkg::sum_type  acc_ff, acc_in;
   logic              ovf_ff, ovf_in;
   mvm_pkg::sum_type  raw_sum;
   mvm_pkg::sum_type  sat_sum;
   logic              clamp;
   logic              emit;

   assign raw_sum = acc_ff + prod_ff;
   assign clamp   = (acc_ff[63] == prod_ff[63]) && (raw_sum[63] != acc_ff[63]);
   assign sat_sum = clamp ? (acc_ff[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}}) : raw_sum;
   assign emit    = s2_valid_ff && s2_ctrl_ff.is_mac && s2_ctrl_ff.end_row;

   always_comb begin
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      if (adv && s2_valid_ff) begin
         if (!s2_ctrl_ff.is_mac || s2_ctrl_ff.end_row) begin
            acc_in = '0;
            ovf_in = 1'b0;
         end else begin
            acc_in = sat_sum;
            ovf_in = ovf_ff | clamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         ovf_ff <= ovf_in;
         if (adv) begin
            s2_valid_ff  <= s1_valid;
            out_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ctrl_ff <= s1_ctrl;
         prod_ff    <= mvm_pkg::sum_type'(s1_value) * mvm_pkg::sum_type'(vec_data);
         if (emit) begin
            out_word_ff.row_index <= s2_ctrl_ff.row_index;
            out_word_ff.row_sum   <= sat_sum;
            out_word_ff.saturated <= ovf_ff | clamp;
            out_word_ff.last_row  <= s2_ctrl_ff.last;
         end
      end
   end

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      adv && emit |=> out_valid_ff)
      else $error("finished row not presented");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      adv && s2_valid_ff && !s2_ctrl_ff.is_mac |=> acc_ff == '0 && !ovf_ff)
      else $error("accumulator not cleared by vector load");

   a_row_end_clears: assert property (@(posedge clock) disable iff (reset)
      adv && emit |=> acc_ff == '0 && !ovf_ff)
      else $error("accumulator not cleared at row end");

endmodule

// ----- rtl/core/matrix_vector_multiply.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Square matrix times vector in Q16.16, row sums in saturating Q32.32.
// ----------------------------------------------------------------------------
// Takes one word per cycle while req_stall is low, vector loads and matrix
// elements alike, and delivers each row sum after the row's final element is
// accepted: the vector memory read is issued at the accepting edge, then the
// 32x32 multiply goes into the product register and the saturating 64-bit
// accumulate into the result register. The vector memory has one write and
// one read port, so a load and an element each use one port in their own
// cycle. While a result waits under rsp_stall the whole pipeline holds and
// req_stall is raised.
module matrix_vector_multiply #(
   parameter int MAX_SIZE = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mvm_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mvm_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  mvm_pkg::size_type     csr_data
);

   localparam int AW = $clog2(MAX_SIZE);

   mvm_pkg::size_type  size_ff;
   logic               adv;
   logic               accept;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   mvm_pkg::value_type wr_data;
   logic [AW-1:0]      rd_addr;
   mvm_pkg::value_type vec_data;
   logic               s1_valid;
   mvm_pkg::ctrl_type  s1_ctrl;
   mvm_pkg::value_type s1_value;

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= mvm_pkg::SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_data;
      end
   end

   mvm_sequencer #(
      .MAX_SIZE (MAX_SIZE)
   ) u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .accept      (accept),
      .req_word    (req_word),
      .size        (size_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .s1_valid_ff (s1_valid),
      .s1_ctrl_ff  (s1_ctrl),
      .s1_value_ff (s1_value)
   );

   mvm_vector_store #(
      .MAX_SIZE (MAX_SIZE)
   ) u_vector_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (adv),
      .rd_addr    (rd_addr),
      .rd_data_ff (vec_data)
   );

   mvm_accumulator u_accumulator (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .s1_valid     (s1_valid),
      .s1_ctrl      (s1_ctrl),
      .s1_value     (s1_value),
      .vec_data     (vec_data),
      .out_valid_ff (rsp_valid),
      .out_word_ff  (rsp_word)
   );

endmodule
